[hdl/bslpd_pkg.sv]
package bslpd_pkg;

  localparam int unsigned NUM_BUTTONS = 4;
  localparam int unsigned PIN_W       = 4;
  localparam int unsigned NUM_LANES   = (NUM_BUTTONS < PIN_W) ? NUM_BUTTONS : PIN_W;
  localparam int unsigned COUNT_W     = 8;
  localparam int unsigned LOCK_W      = 4;
  localparam int unsigned HOLD_W      = 8;
  localparam int unsigned PADDR_W     = 3;
  localparam int unsigned PDATA_W     = 32;

  localparam logic [LOCK_W-1:0] LOCK_TICKS_RST = LOCK_W'(3);
  localparam logic [HOLD_W-1:0] HOLD_TICKS_RST = HOLD_W'(100);

  typedef enum logic [0:0] {
    REG_LOCK_TICKS = 1'b0,
    REG_HOLD_TICKS = 1'b1
  } reg_idx_e;

  typedef struct packed {
    logic [LOCK_W-1:0] lock_ticks;
    logic [HOLD_W-1:0] hold_ticks;
  } cfg_t;

  typedef struct packed {
    logic short_press;
    logic long_press;
  } lane_evt_t;

endpackage

[hdl/bslpd_if.sv]
interface bslpd_in_if;
  logic                         valid;
  logic                         ready;
  logic [bslpd_pkg::PIN_W-1:0]  pin_levels;

  modport source (output valid, output pin_levels, input ready);
  modport sink   (input valid, input pin_levels, output ready);
endinterface

interface bslpd_out_if;
  logic                         valid;
  logic                         ready;
  logic [bslpd_pkg::PIN_W-1:0]  short_press;
  logic [bslpd_pkg::PIN_W-1:0]  long_press;

  modport source (output valid, output short_press, output long_press, input ready);
  modport sink   (input valid, input short_press, input long_press, output ready);
endinterface

[hdl/bslpd_lane.sv]
module bslpd_lane (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 en_i,
  input  logic                 pressed_i,
  input  bslpd_pkg::cfg_t      cfg_i,
  output bslpd_pkg::lane_evt_t evt_o
);

  logic [bslpd_pkg::COUNT_W-1:0] count_q, count_d, count_inc;
  logic                          locked_q, locked_d;
  logic                          held_q, held_d;

  assign count_inc = count_q + bslpd_pkg::COUNT_W'(1);

  always_comb begin
    count_d           = count_q;
    locked_d          = locked_q;
    held_d            = held_q;
    evt_o.short_press = 1'b0;
    evt_o.long_press  = 1'b0;
    if (locked_q) begin
      if (pressed_i) begin
        if (!held_q) begin
          count_d = count_inc;
          if (count_inc == cfg_i.hold_ticks) begin
            held_d           = 1'b1;
            evt_o.long_press = 1'b1;
          end
        end
      end else begin
        evt_o.short_press = !held_q;
        held_d            = 1'b0;
        locked_d          = 1'b0;
        count_d           = '0;
      end
    end else begin
      if (pressed_i) begin
        count_d = count_inc;
        if (count_inc == bslpd_pkg::COUNT_W'(cfg_i.lock_ticks)) begin
          locked_d = 1'b1;
        end
      end else begin
        count_d = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q  <= '0;
      locked_q <= 1'b0;
      held_q   <= 1'b0;
    end else if (en_i) begin
      count_q  <= count_d;
      locked_q <= locked_d;
      held_q   <= held_d;
    end
  end

endmodule

[hdl/bslpd_merge.sv]
module bslpd_merge (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 accept_i,
  input  bslpd_pkg::lane_evt_t evt_i [bslpd_pkg::NUM_LANES],
  output logic                 ready_o,
  bslpd_out_if.source          out_o
);

  logic                          valid_q;
  logic [bslpd_pkg::PIN_W-1:0]   short_q, short_d;
  logic [bslpd_pkg::PIN_W-1:0]   long_q, long_d;

  always_comb begin
    short_d = '0;
    long_d  = '0;
    for (int unsigned i = 0; i < bslpd_pkg::NUM_LANES; i++) begin
      short_d[i] = evt_i[i].short_press;
      long_d[i]  = evt_i[i].long_press;
    end
  end

  assign ready_o = !valid_q || out_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= accept_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      short_q <= short_d;
      long_q  <= long_d;
    end
  end

  assign out_o.valid       = valid_q;
  assign out_o.short_press = short_q;
  assign out_o.long_press  = long_q;

endmodule

[hdl/button_short_long_press_detector.sv]
// Each accepted item's result is captured in the output register at the edge that accepts it.
// One item per cycle unless stalled; each button has its own lane, all lanes step together.
// A stalled output holds the result and blocks input only while the output register is full.
// Reset (rst_ni low, asynchronous): counters and flags clear, output empties,
// lock_ticks returns to 3 and hold_ticks to 100.
module button_short_long_press_detector (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  bslpd_in_if.sink                        in_i,
  bslpd_out_if.source                     out_o,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [bslpd_pkg::PADDR_W-1:0]   paddr,
  input  logic [bslpd_pkg::PDATA_W-1:0]   pwdata,
  output logic [bslpd_pkg::PDATA_W-1:0]   prdata,
  output logic                            pready
);

  bslpd_pkg::cfg_t       cfg_q;
  bslpd_pkg::reg_idx_e   reg_idx;
  bslpd_pkg::lane_evt_t  evt [bslpd_pkg::NUM_LANES];
  logic                  ready;
  logic                  accept;
  logic                  cfg_wr;

  assign pready  = 1'b1;
  assign reg_idx = bslpd_pkg::reg_idx_e'(paddr[2]);
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.lock_ticks <= bslpd_pkg::LOCK_TICKS_RST;
      cfg_q.hold_ticks <= bslpd_pkg::HOLD_TICKS_RST;
    end else if (cfg_wr) begin
      case (reg_idx)
        bslpd_pkg::REG_LOCK_TICKS: cfg_q.lock_ticks <= pwdata[bslpd_pkg::LOCK_W-1:0];
        bslpd_pkg::REG_HOLD_TICKS: cfg_q.hold_ticks <= pwdata[bslpd_pkg::HOLD_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      bslpd_pkg::REG_LOCK_TICKS: prdata = bslpd_pkg::PDATA_W'(cfg_q.lock_ticks);
      bslpd_pkg::REG_HOLD_TICKS: prdata = bslpd_pkg::PDATA_W'(cfg_q.hold_ticks);
      default:                   prdata = '0;
    endcase
  end

  assign in_i.ready = ready;
  assign accept     = in_i.valid && ready;

  for (genvar g = 0; g < bslpd_pkg::NUM_LANES; g++) begin : g_lane
    bslpd_lane u_lane (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .en_i      (accept),
      .pressed_i (!in_i.pin_levels[g]),
      .cfg_i     (cfg_q),
      .evt_o     (evt[g])
    );
  end

  bslpd_merge u_merge (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .evt_i    (evt),
    .ready_o  (ready),
    .out_o    (out_o)
  );

endmodule

[tb/button_short_long_press_detector_tb.sv]
`timescale 1ns / 1ps

module button_short_long_press_detector_tb;
  import bslpd_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int LONG_STALL  = 60;

  typedef struct packed {
    logic [PIN_W-1:0] short_press;
    logic [PIN_W-1:0] long_press;
  } press_evt_t;

  class press_event_model;
    logic [LOCK_W-1:0]  lock_ticks;
    logic [HOLD_W-1:0]  hold_ticks;
    logic [COUNT_W-1:0] press_count[NUM_LANES];
    bit                 locked[NUM_LANES];
    bit                 held[NUM_LANES];
    press_evt_t         expected_events[$];
    int                 errors;
    int                 ticks;
    int                 short_pulses;
    int                 long_pulses;

    function new();
      lock_ticks = LOCK_TICKS_RST;
      hold_ticks = HOLD_TICKS_RST;
      for (int i = 0; i < NUM_LANES; i++) begin
        press_count[i] = '0;
        locked[i]      = 1'b0;
        held[i]        = 1'b0;
      end
      errors       = 0;
      ticks        = 0;
      short_pulses = 0;
      long_pulses  = 0;
    endfunction

    function void set_register(reg_idx_e idx, logic [PDATA_W-1:0] value);
      case (idx)
        REG_LOCK_TICKS: lock_ticks = value[LOCK_W-1:0];
        REG_HOLD_TICKS: hold_ticks = value[HOLD_W-1:0];
        default: ;
      endcase
    endfunction

    function void note_tick(logic [PIN_W-1:0] pins);
      press_evt_t evt;
      bit         pressed;
      evt = '0;
      for (int i = 0; i < NUM_LANES; i++) begin
        pressed = !pins[i];
        if (locked[i]) begin
          if (pressed) begin
            if (!held[i]) begin
              press_count[i] = press_count[i] + 1'b1;
              if (press_count[i] == hold_ticks) begin
                held[i]            = 1'b1;
                evt.long_press[i]  = 1'b1;
              end
            end
          end else begin
            if (held[i]) held[i] = 1'b0;
            else evt.short_press[i] = 1'b1;
            press_count[i] = '0;
            locked[i]      = 1'b0;
          end
        end else if (pressed) begin
          press_count[i] = press_count[i] + 1'b1;
          if (press_count[i] == lock_ticks) locked[i] = 1'b1;
        end else begin
          press_count[i] = '0;
        end
      end
      ticks++;
      short_pulses += $countones(evt.short_press);
      long_pulses  += $countones(evt.long_press);
      expected_events.push_back(evt);
    endfunction

    function void check_events(logic [PIN_W-1:0] short_got, logic [PIN_W-1:0] long_got);
      press_evt_t evt;
      if (expected_events.size() == 0) begin
        $display("%0t: unexpected item, expected none, got short %h long %h",
                 $time, short_got, long_got);
        errors++;
        return;
      end
      evt = expected_events.pop_front();
      if (short_got !== evt.short_press) begin
        $display("%0t: short_press mismatch, expected %h, got %h",
                 $time, evt.short_press, short_got);
        errors++;
      end
      if (long_got !== evt.long_press) begin
        $display("%0t: long_press mismatch, expected %h, got %h",
                 $time, evt.long_press, long_got);
        errors++;
      end
    endfunction

    function int pending();
      return expected_events.size();
    endfunction
  endclass

  logic               clk_i;
  logic               rst_ni;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [PDATA_W-1:0] pwdata;
  logic [PDATA_W-1:0] prdata;
  logic               pready;

  bslpd_in_if  in_ch ();
  bslpd_out_if out_ch ();

  button_short_long_press_detector dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (in_ch),
    .out_o   (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  press_event_model model = new();

  bit idle_on;
  bit long_stall_req;
  int press_left[NUM_BUTTONS];
  int rest_left[NUM_BUTTONS];
  int cycle_count;
  int settings_done;

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  initial begin
    cycle_count = 0;
    forever begin
      @(posedge clk_i);
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
        $display("Run stopped at the cycle limit with %0d items outstanding",
                 model.pending());
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  initial begin : result_sink
    int stall_left;
    stall_left = 0;
    wait (rst_ni === 1'b1);
    forever begin
      @(posedge clk_i);
      if (out_ch.valid && out_ch.ready)
        model.check_events(out_ch.short_press, out_ch.long_press);
      if (stall_left > 0) stall_left--;
      else if (long_stall_req) begin
        long_stall_req = 1'b0;
        stall_left     = LONG_STALL;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(1, 5);
      end
      out_ch.ready <= (stall_left == 0);
    end
  end

  task automatic write_register(input reg_idx_e idx, input logic [PDATA_W-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    model.set_register(idx, value);
  endtask

  task automatic apply_setting(input logic [LOCK_W-1:0] lock, input logic [HOLD_W-1:0] hold);
    while (model.pending() != 0) @(posedge clk_i);
    repeat (2) @(posedge clk_i);
    write_register(REG_LOCK_TICKS, PDATA_W'(lock));
    write_register(REG_HOLD_TICKS, PDATA_W'(hold));
    settings_done++;
  endtask

  task automatic send_tick(input logic [PIN_W-1:0] pins);
    int gap;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 5);
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_ch.valid      <= 1'b1;
    in_ch.pin_levels <= pins;
    do @(posedge clk_i); while (!in_ch.ready);
    model.note_tick(pins);
  endtask

  task automatic run_setting(input logic [LOCK_W-1:0] lock, input logic [HOLD_W-1:0] hold,
                             input int n_items, input bit idle, input bit stall);
    logic [COUNT_W-1:0] cnt;
    bit                 lk;
    int                 need;
    int                 lock_t;
    int                 len;
    logic [PIN_W-1:0]   pins;
    apply_setting(lock, hold);
    idle_on        = idle;
    long_stall_req = stall;
    cnt  = '0;
    lk   = 1'b0;
    need = 0;
    for (int t = 1; t <= 600 && need == 0; t++) begin
      cnt = cnt + 1'b1;
      if (lk) begin
        if (cnt == hold) need = t;
      end else if (cnt == lock) lk = 1'b1;
    end
    lock_t = (lock == 0) ? 256 : int'(lock);
    for (int b = 0; b < NUM_BUTTONS; b++) begin
      press_left[b] = 0;
      rest_left[b]  = 0;
    end
    repeat (n_items) begin
      pins = '1;
      for (int b = 0; b < NUM_BUTTONS; b++) begin
        if (press_left[b] == 0 && rest_left[b] == 0) begin
          case ($urandom_range(0, 5))
            0: len = $urandom_range(1, 3);
            1: len = $urandom_range((lock_t > 1) ? lock_t - 1 : 1, lock_t + 1);
            2: len = $urandom_range(lock_t + 1, lock_t + 10);
            3, 4: len = $urandom_range((need > 1) ? need - 1 : 1, need + 4);
            default: len = $urandom_range(1, 40);
          endcase
          press_left[b] = len;
          rest_left[b]  = $urandom_range(1, 4);
        end
        if (press_left[b] > 0) begin
          pins[b] = 1'b0;
          press_left[b]--;
        end else begin
          pins[b] = 1'b1;
          rest_left[b]--;
        end
      end
      if ($urandom_range(0, 15) == 0) pins[$urandom_range(0, PIN_W - 1)] ^= 1'b1;
      if ($urandom_range(0, 39) == 0) pins = PIN_W'($urandom_range(0, 15));
      send_tick(pins);
    end
    in_ch.valid <= 1'b0;
  endtask

  initial begin
    logic [PIN_W-1:0] reset_seq[$];
    logic [PIN_W-1:0] fast_seq[$];
    rst_ni           = 1'b0;
    psel             = 1'b0;
    penable          = 1'b0;
    pwrite           = 1'b0;
    paddr            = '0;
    pwdata           = '0;
    in_ch.valid      = 1'b0;
    in_ch.pin_levels = '1;
    out_ch.ready     = 1'b0;
    idle_on          = 1'b1;
    long_stall_req   = 1'b0;
    settings_done    = 1;
    reset_seq = '{4'h0, 4'h0, 4'h0, 4'hF, 4'hE, 4'hE, 4'hF,
                  4'h5, 4'h5, 4'h5, 4'hA, 4'hF};
    fast_seq  = '{4'h0, 4'h0, 4'h0, 4'h0, 4'h0, 4'h0, 4'h0, 4'h0,
                  4'h0, 4'h0, 4'h0, 4'h0, 4'hF, 4'h0, 4'hF};
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (reset_seq[k]) send_tick(reset_seq[k]);
    in_ch.valid <= 1'b0;
    apply_setting(4'd1, 8'd11);
    foreach (fast_seq[k]) send_tick(fast_seq[k]);
    in_ch.valid <= 1'b0;

    run_setting(4'd3,  8'd100, 140, 1'b1, 1'b1);
    run_setting(4'd1,  8'd255, 280, 1'b1, 1'b0);
    run_setting(4'd0,  8'd20,  300, 1'b0, 1'b0);
    run_setting(4'd15, 8'd0,   280, 1'b1, 1'b0);
    run_setting(4'd10, 8'd11,  60,  1'b1, 1'b1);
    run_setting(LOCK_W'($urandom_range(0, 15)), HOLD_W'($urandom_range(0, 255)),
                60, 1'b1, 1'b0);
    run_setting(4'd2,  8'd13,  80,  1'b0, 1'b0);

    while (model.pending() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);

    $display("Checked %0d ticks over %0d register settings, lock 0..15 and hold 0..255 ends",
             model.ticks, settings_done);
    $display("Predicted %0d short and %0d long press pulses",
             model.short_pulses, model.long_pulses);
    if (model.errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
